// File: sv/tilemap_scroll_copy_generator_assert.svh
// ----------------------------------------------------------------------------
// tilemap scroll copy generator assertion macros
// shared concurrent assertion forms, clocked on clock, quiet during reset
// ----------------------------------------------------------------------------
`ifndef TILEMAP_SCROLL_COPY_GENERATOR_ASSERT_SVH
`define TILEMAP_SCROLL_COPY_GENERATOR_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define TSC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tilemap scroll copy generator: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define TSC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tilemap scroll copy generator: next-cycle check failed");

`endif

// File: sv/tsc_pkg.sv
// ----------------------------------------------------------------------------
// tsc_pkg
// shared widths, codes and the copy command type of the scroll copy generator
// ----------------------------------------------------------------------------
`default_nettype none

package tsc_pkg;

   localparam int SCREEN_TILES_W_DEF = 32;
   localparam int SCREEN_TILES_H_DEF = 24;
   localparam int MAX_MAP_TILES_DEF  = 1024;

   localparam int KIND_W      = 3;
   localparam int COORD_W     = 16;
   localparam int ROW_OFS_W   = 5;
   localparam int CFG_W       = 11;
   localparam int CSR_INDEX_W = 4;
   localparam int SRC_W       = 21;
   localparam int DST_W       = 11;
   localparam int SCROLL_W    = 13;
   localparam int COL_W       = 6;
   localparam int ROW_W       = 5;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_STEP_RIGHT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_STEP_LEFT  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_STEP_DOWN  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_STEP_UP    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_SET_POS    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_LOAD_ROW   = 3'd5;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_TILE_COLS = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TILE_ROWS = 4'd1;

   localparam logic [CFG_W-1:0] TILE_COLS_RESET = 11'd64;
   localparam logic [CFG_W-1:0] TILE_ROWS_RESET = 11'd32;

   // one classified transaction, front to back
   typedef struct packed {
      logic                copy;
      logic                vertical;
      logic [SRC_W-1:0]    src;
      logic [COL_W-1:0]    col;
      logic [ROW_W-1:0]    row;
      logic [SCROLL_W-1:0] scroll_x;
      logic [SCROLL_W-1:0] scroll_y;
   } copy_cmd_type;

endpackage

`default_nettype wire

// File: sv/tsc_front.sv
// ----------------------------------------------------------------------------
// tsc_front
// accepts transactions, keeps the scroll position and classifies each step
// ----------------------------------------------------------------------------
`default_nettype none

module tsc_front
   import tsc_pkg::*;
#(
   parameter int SCREEN_TILES_W = SCREEN_TILES_W_DEF,
   parameter int SCREEN_TILES_H = SCREEN_TILES_H_DEF,
   parameter int MAX_MAP_TILES  = MAX_MAP_TILES_DEF,
   localparam int EW = $clog2(MAX_MAP_TILES + 1)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [CFG_W-1:0]            tile_cols,
   input  wire logic [CFG_W-1:0]            tile_rows,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [KIND_W-1:0]           req_kind,
   input  wire logic signed [COORD_W-1:0]   req_pos_x,
   input  wire logic signed [COORD_W-1:0]   req_pos_y,
   input  wire logic [ROW_OFS_W-1:0]        req_row_offset,
   output logic [EW-1:0]                    eff_width,
   output logic                             push,
   output copy_cmd_type                     push_cmd,
   input  wire logic                        full
);

   localparam int PW     = EW + 3;
   localparam int TCW    = EW + 1;
   localparam int CW     = (CFG_W > EW) ? CFG_W : EW;
   localparam int PROD_W = TCW + EW;
   localparam int SUM_W  = PROD_W + SRC_W;
   localparam int SW     = PW + COORD_W;

   logic [EW-1:0]  eff_height;
   logic [PW-1:0]  limit_x;
   logic [PW-1:0]  limit_y;
   logic [TCW-1:0] tile_x;
   logic [TCW-1:0] tile_y;
   logic [PW-1:0]  set_x;
   logic [PW-1:0]  set_y;
   logic           accept;

   logic [PW-1:0]  pos_x_ff, pos_x_in;
   logic [PW-1:0]  pos_y_ff, pos_y_in;
   logic           stg_valid_ff, stg_valid_in;
   logic           stg_copy_ff, stg_copy_in;
   logic           stg_vert_ff, stg_vert_in;
   logic [TCW-1:0] stg_col_ff, stg_col_in;
   logic [TCW-1:0] stg_row_ff, stg_row_in;

   logic [PROD_W-1:0] prod;
   logic [SUM_W-1:0]  sum;

   // map size saturated to the legal range
   always_comb begin
      if (CW'(tile_cols) < CW'(SCREEN_TILES_W)) begin
         eff_width = EW'(SCREEN_TILES_W);
      end else if (CW'(tile_cols) > CW'(MAX_MAP_TILES)) begin
         eff_width = EW'(MAX_MAP_TILES);
      end else begin
         eff_width = EW'(tile_cols);
      end
      if (CW'(tile_rows) < CW'(SCREEN_TILES_H)) begin
         eff_height = EW'(SCREEN_TILES_H);
      end else if (CW'(tile_rows) > CW'(MAX_MAP_TILES)) begin
         eff_height = EW'(MAX_MAP_TILES);
      end else begin
         eff_height = EW'(tile_rows);
      end
   end

   assign limit_x = {eff_width - EW'(SCREEN_TILES_W), 3'b000};
   assign limit_y = {eff_height - EW'(SCREEN_TILES_H), 3'b000};
   assign tile_x  = TCW'(pos_x_ff[PW-1:3]);
   assign tile_y  = TCW'(pos_y_ff[PW-1:3]);

   // set position clamp
   always_comb begin
      if (req_pos_x[COORD_W-1]) begin
         set_x = '0;
      end else if (SW'($unsigned(req_pos_x)) > SW'(limit_x)) begin
         set_x = limit_x;
      end else begin
         set_x = PW'($unsigned(req_pos_x));
      end
      if (req_pos_y[COORD_W-1]) begin
         set_y = '0;
      end else if (SW'($unsigned(req_pos_y)) > SW'(limit_y)) begin
         set_y = limit_y;
      end else begin
         set_y = PW'($unsigned(req_pos_y));
      end
   end

   assign req_stall = stg_valid_ff && full;
   assign accept    = req_valid && !req_stall;
   assign push      = stg_valid_ff && !full;

   always_comb begin
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      stg_copy_in  = stg_copy_ff;
      stg_vert_in  = stg_vert_ff;
      stg_col_in   = stg_col_ff;
      stg_row_in   = stg_row_ff;
      stg_valid_in = push ? 1'b0 : stg_valid_ff;
      if (accept) begin
         stg_valid_in = 1'b1;
         stg_copy_in  = 1'b0;
         stg_vert_in  = 1'b0;
         stg_col_in   = tile_x;
         stg_row_in   = tile_y;
         case (req_kind)
            KIND_STEP_RIGHT: begin
               if (pos_x_ff < limit_x) begin
                  pos_x_in = pos_x_ff + PW'(1);
                  if (pos_x_ff[2:0] == 3'b111) begin
                     stg_copy_in = 1'b1;
                     stg_vert_in = 1'b1;
                     stg_col_in  = tile_x + TCW'(SCREEN_TILES_W + 1);
                  end
               end
            end
            KIND_STEP_LEFT: begin
               if (pos_x_ff != '0) begin
                  pos_x_in = pos_x_ff - PW'(1);
                  if (pos_x_ff[2:0] == 3'b000) begin
                     stg_copy_in = 1'b1;
                     stg_vert_in = 1'b1;
                     stg_col_in  = tile_x - TCW'(1);
                  end
               end
            end
            KIND_STEP_DOWN: begin
               if (pos_y_ff < limit_y) begin
                  pos_y_in = pos_y_ff + PW'(1);
                  if (pos_y_ff[2:0] == 3'b111) begin
                     stg_copy_in = 1'b1;
                     stg_row_in  = tile_y + TCW'(SCREEN_TILES_H + 1);
                  end
               end
            end
            KIND_STEP_UP: begin
               if (pos_y_ff != '0) begin
                  pos_y_in = pos_y_ff - PW'(1);
                  if (pos_y_ff[2:0] == 3'b000) begin
                     stg_copy_in = 1'b1;
                     stg_row_in  = tile_y - TCW'(1);
                  end
               end
            end
            KIND_SET_POS: begin
               pos_x_in = set_x;
               pos_y_in = set_y;
            end
            KIND_LOAD_ROW: begin
               stg_copy_in = 1'b1;
               stg_row_in  = tile_y + TCW'(req_row_offset);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         stg_valid_ff <= 1'b0;
      end else begin
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         stg_valid_ff <= stg_valid_in;
      end
   end

   // stage payload; scroll taken from the position registers, already updated
   always_ff @(posedge clock) begin
      stg_copy_ff <= stg_copy_in;
      stg_vert_ff <= stg_vert_in;
      stg_col_ff  <= stg_col_in;
      stg_row_ff  <= stg_row_in;
   end

   // source index of the first copy
   assign prod = PROD_W'(stg_row_ff) * PROD_W'(eff_width);
   assign sum  = SUM_W'(prod) + SUM_W'(stg_col_ff);

   always_comb begin
      push_cmd.copy     = stg_copy_ff;
      push_cmd.vertical = stg_vert_ff;
      push_cmd.src      = sum[SRC_W-1:0];
      push_cmd.col      = stg_col_ff[COL_W-1:0];
      push_cmd.row      = stg_row_ff[ROW_W-1:0];
      push_cmd.scroll_x = SCROLL_W'(pos_x_ff);
      push_cmd.scroll_y = SCROLL_W'(pos_y_ff);
   end

endmodule

`default_nettype wire

// File: sv/tsc_queue.sv
// ----------------------------------------------------------------------------
// tsc_queue
// two-entry command queue between classifier and copy cursor
// ----------------------------------------------------------------------------
`default_nettype none

module tsc_queue
   import tsc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire copy_cmd_type  push_cmd,
   output logic               full,
   input  wire logic          pop,
   output copy_cmd_type       pop_cmd,
   output logic               not_empty
);

   localparam int DEPTH = 2;
   localparam int AW    = $clog2(DEPTH);
   localparam int CNTW  = $clog2(DEPTH + 1);

   copy_cmd_type    entry_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0] count_ff, count_in;

   assign full      = (count_ff == CNTW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNTW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// File: sv/tsc_back.sv
// ----------------------------------------------------------------------------
// tsc_back
// copy cursor: walks each burst, one copy per cycle while rsp_stall is low, into the result register
// ----------------------------------------------------------------------------
`default_nettype none

module tsc_back
   import tsc_pkg::*;
#(
   parameter int SCREEN_TILES_W = SCREEN_TILES_W_DEF,
   parameter int SCREEN_TILES_H = SCREEN_TILES_H_DEF,
   parameter int MAX_MAP_TILES  = MAX_MAP_TILES_DEF,
   localparam int EW = $clog2(MAX_MAP_TILES + 1)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [EW-1:0]        eff_width,
   input  wire logic                 cmd_valid,
   input  wire copy_cmd_type         cmd,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic                      rsp_copy_valid,
   output logic [SRC_W-1:0]          rsp_source_entry,
   output logic [DST_W-1:0]          rsp_dest_entry,
   output logic [SCROLL_W-1:0]       rsp_scroll_x,
   output logic [SCROLL_W-1:0]       rsp_scroll_y,
   output logic                      rsp_last
);

   localparam int MAXN  = ((SCREEN_TILES_W > SCREEN_TILES_H) ?
                           SCREEN_TILES_W : SCREEN_TILES_H) + 1;
   localparam int CNT_W = $clog2(MAXN + 1);

   logic                slot_free;
   logic                busy;
   logic                emit;
   logic                cur_copy;
   logic                cur_vert;
   logic [SRC_W-1:0]    cur_src;
   logic [COL_W-1:0]    cur_col;
   logic [ROW_W-1:0]    cur_row;
   logic [SCROLL_W-1:0] cur_sx;
   logic [SCROLL_W-1:0] cur_sy;
   logic [CNT_W-1:0]    cur_rem;

   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic                vert_ff, vert_in;
   logic [SRC_W-1:0]    src_ff, src_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [SCROLL_W-1:0] sx_ff, sx_in;
   logic [SCROLL_W-1:0] sy_ff, sy_in;

   logic                out_valid_ff, out_valid_in;
   logic                out_copy_ff, out_copy_in;
   logic [SRC_W-1:0]    out_src_ff, out_src_in;
   logic [DST_W-1:0]    out_dst_ff, out_dst_in;
   logic [SCROLL_W-1:0] out_sx_ff, out_sx_in;
   logic [SCROLL_W-1:0] out_sy_ff, out_sy_in;
   logic                out_last_ff, out_last_in;

   assign slot_free = !out_valid_ff || !rsp_stall;
   assign busy      = (rem_ff != '0);
   assign emit      = slot_free && (busy || cmd_valid);
   assign pop       = slot_free && !busy && cmd_valid;

   // a running burst goes first, otherwise the head of the queue
   always_comb begin
      if (busy) begin
         cur_copy = 1'b1;
         cur_vert = vert_ff;
         cur_src  = src_ff;
         cur_col  = col_ff;
         cur_row  = row_ff;
         cur_sx   = sx_ff;
         cur_sy   = sy_ff;
         cur_rem  = rem_ff;
      end else begin
         cur_copy = cmd.copy;
         cur_vert = cmd.vertical;
         cur_src  = cmd.src;
         cur_col  = cmd.col;
         cur_row  = cmd.row;
         cur_sx   = cmd.scroll_x;
         cur_sy   = cmd.scroll_y;
         cur_rem  = cmd.vertical ? CNT_W'(SCREEN_TILES_H + 1) : CNT_W'(SCREEN_TILES_W + 1);
      end
   end

   always_comb begin
      rem_in       = rem_ff;
      vert_in      = vert_ff;
      src_in       = src_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_copy_in  = out_copy_ff;
      out_src_in   = out_src_ff;
      out_dst_in   = out_dst_ff;
      out_sx_in    = out_sx_ff;
      out_sy_in    = out_sy_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_copy_in  = cur_copy;
         out_sx_in    = cur_sx;
         out_sy_in    = cur_sy;
         if (cur_copy) begin
            out_src_in  = cur_src;
            out_dst_in  = {cur_col[COL_W-1], cur_row, cur_col[COL_W-2:0]};
            out_last_in = (cur_rem == CNT_W'(1));
            rem_in      = cur_rem - CNT_W'(1);
            vert_in     = cur_vert;
            src_in      = cur_src + (cur_vert ? SRC_W'(eff_width) : SRC_W'(1));
            col_in      = cur_vert ? cur_col : cur_col + COL_W'(1);
            row_in      = cur_vert ? cur_row + ROW_W'(1) : cur_row;
            sx_in       = cur_sx;
            sy_in       = cur_sy;
         end else begin
            out_src_in  = '0;
            out_dst_in  = '0;
            out_last_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         rem_ff       <= rem_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      vert_ff     <= vert_in;
      src_ff      <= src_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      out_copy_ff <= out_copy_in;
      out_src_ff  <= out_src_in;
      out_dst_ff  <= out_dst_in;
      out_sx_ff   <= out_sx_in;
      out_sy_ff   <= out_sy_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_copy_valid   = out_copy_ff;
   assign rsp_source_entry = out_src_ff;
   assign rsp_dest_entry   = out_dst_ff;
   assign rsp_scroll_x     = out_sx_ff;
   assign rsp_scroll_y     = out_sy_ff;
   assign rsp_last         = out_last_ff;

endmodule

`default_nettype wire

// File: sv/tilemap_scroll_copy_generator.sv
// ----------------------------------------------------------------------------
// tilemap_scroll_copy_generator
// scroll position keeper and tile copy list generator for a streamed tile map
// ----------------------------------------------------------------------------
// Each request transaction is a one-pixel step, a set position or a load row.
// A step that stays inside a tile, a step at the limit, a set position or an
// unknown kind returns a single status response (copy_valid low, last high).
// A step that crosses a tile boundary returns a column burst of
// SCREEN_TILES_H+1 copies (25 by default) or a row burst of SCREEN_TILES_W+1
// copies (33 by default), and a load row returns a row burst; the copy
// cursor of the back end walks the burst one entry per cycle and holds it
// while rsp_stall is high. A request passes the front-end stage register,
// the command queue and the back-end response register before its first
// response is on the ports. The front end keeps the position and holds one
// classified request; it stalls requests only while that request cannot
// enter the full two-entry command queue, so up to three requests wait ahead
// of a running burst. Every response carries the position after its request.
// Map size registers are to be written only while the block is idle; the
// block itself does not enforce this. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module tilemap_scroll_copy_generator
   import tsc_pkg::*;
#(
   parameter int SCREEN_TILES_W = SCREEN_TILES_W_DEF,
   parameter int SCREEN_TILES_H = SCREEN_TILES_H_DEF,
   parameter int MAX_MAP_TILES  = MAX_MAP_TILES_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // register write port
   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [CFG_W-1:0]          csr_write_data,
   // request channel
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [KIND_W-1:0]         req_kind,
   input  wire logic signed [COORD_W-1:0] req_pos_x,
   input  wire logic signed [COORD_W-1:0] req_pos_y,
   input  wire logic [ROW_OFS_W-1:0]      req_row_offset,
   // response channel
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic                           rsp_copy_valid,
   output logic [SRC_W-1:0]               rsp_source_entry,
   output logic [DST_W-1:0]               rsp_dest_entry,
   output logic [SCROLL_W-1:0]            rsp_scroll_x,
   output logic [SCROLL_W-1:0]            rsp_scroll_y,
   output logic                           rsp_last
);

   localparam int EW = $clog2(MAX_MAP_TILES + 1);

   logic [CFG_W-1:0] tile_cols_ff, tile_cols_in;
   logic [CFG_W-1:0] tile_rows_ff, tile_rows_in;

   logic [EW-1:0]    eff_width;
   logic             push;
   copy_cmd_type     push_cmd;
   logic             full;
   logic             pop;
   copy_cmd_type     pop_cmd;
   logic             not_empty;

   // map size registers keep the written bits, saturation happens on use
   always_comb begin
      tile_cols_in = tile_cols_ff;
      tile_rows_in = tile_rows_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_TILE_COLS: tile_cols_in = csr_write_data;
            CSR_TILE_ROWS: tile_rows_in = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_cols_ff <= TILE_COLS_RESET;
         tile_rows_ff <= TILE_ROWS_RESET;
      end else begin
         tile_cols_ff <= tile_cols_in;
         tile_rows_ff <= tile_rows_in;
      end
   end

   // front end: position, limits and burst start
   tsc_front #(
      .SCREEN_TILES_W (SCREEN_TILES_W),
      .SCREEN_TILES_H (SCREEN_TILES_H),
      .MAX_MAP_TILES  (MAX_MAP_TILES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .tile_cols      (tile_cols_ff),
      .tile_rows      (tile_rows_ff),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_row_offset (req_row_offset),
      .eff_width      (eff_width),
      .push           (push),
      .push_cmd       (push_cmd),
      .full           (full)
   );

   // decouples classification from burst output
   tsc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (full),
      .pop       (pop),
      .pop_cmd   (pop_cmd),
      .not_empty (not_empty)
   );

   // back end: one copy per cycle into the response register while rsp_stall is low
   tsc_back #(
      .SCREEN_TILES_W (SCREEN_TILES_W),
      .SCREEN_TILES_H (SCREEN_TILES_H),
      .MAX_MAP_TILES  (MAX_MAP_TILES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .eff_width        (eff_width),
      .cmd_valid        (not_empty),
      .cmd              (pop_cmd),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_copy_valid   (rsp_copy_valid),
      .rsp_source_entry (rsp_source_entry),
      .rsp_dest_entry   (rsp_dest_entry),
      .rsp_scroll_x     (rsp_scroll_x),
      .rsp_scroll_y     (rsp_scroll_y),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire

// File: sv/tsc_checker.sv
// ----------------------------------------------------------------------------
// tsc_checker
// port-level checks on the response channel, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "tilemap_scroll_copy_generator_assert.svh"

module tsc_checker
   import tsc_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire logic                rsp_copy_valid,
   input wire logic [SRC_W-1:0]    rsp_source_entry,
   input wire logic [DST_W-1:0]    rsp_dest_entry,
   input wire logic [SCROLL_W-1:0] rsp_scroll_x,
   input wire logic [SCROLL_W-1:0] rsp_scroll_y,
   input wire logic                rsp_last
);

   localparam int FIELDS_W = 2 + SRC_W + DST_W + 2 * SCROLL_W;

   logic                  take_more;
   logic [2*SCROLL_W-1:0] rsp_scroll;
   logic [FIELDS_W-1:0]   rsp_fields;

   assign take_more  = rsp_valid && !rsp_stall && !rsp_last;
   assign rsp_scroll = {rsp_scroll_x, rsp_scroll_y};
   assign rsp_fields = {rsp_copy_valid, rsp_source_entry, rsp_dest_entry, rsp_scroll, rsp_last};

   // a status response always closes its transaction
   `TSC_ASSERT_SAME(a_status_is_last, rsp_valid && !rsp_copy_valid, rsp_last)

   // a burst runs without gaps once its first copy is taken
   `TSC_ASSERT_NEXT(a_burst_no_gap, take_more, rsp_valid && rsp_copy_valid)

   // all copies of one burst report the same position
   `TSC_ASSERT_NEXT(a_burst_scroll_steady, take_more, $stable(rsp_scroll))

   // stalled response holds
   `TSC_ASSERT_NEXT(a_stall_holds, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_fields))

endmodule

bind tilemap_scroll_copy_generator tsc_checker u_tsc_checker (.*);

`default_nettype wire
